[design/trkvt_pkg.sv]
package trkvt_pkg;

   localparam int HOLD_DEPTH  = 5;
   localparam int FLUSH_DEPTH = HOLD_DEPTH + 1;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_QUOTE = 8'h22;

   typedef enum logic [2:0] {
      MODE_SEEK    = 3'd0,
      MODE_KEY     = 3'd1,
      MODE_ATTR    = 3'd2,
      MODE_VALUE   = 3'd3,
      MODE_TAGOPEN = 3'd4,
      MODE_CLOSE   = 3'd5
   } mode_type;

   // One accepted byte, expanded by the back end in this order:
   // held bytes, main byte, key end, row-end held bytes, value end, row done.
   typedef struct packed {
      logic [FLUSH_DEPTH-1:0][7:0] flush_bytes;
      logic [2:0]                  pre_cnt;
      logic                        main_en;
      logic [7:0]                  main_byte;
      logic                        main_kind;
      logic                        key_end;
      logic                        key_trunc;
      logic [2:0]                  post_cnt;
      logic                        value_end;
      logic                        row_done;
   } cmd_type;

   // entity spellings: &lt; &gt; &amp; &quot;
   function automatic logic [7:0] ent_text(input logic [1:0] e, input logic [2:0] i);
      logic [7:0] ch;
      ch = 8'h00;
      case ({e, i})
         5'b00_000, 5'b01_000, 5'b10_000, 5'b11_000: ch = CH_AMP;
         5'b00_001: ch = 8'h6C;
         5'b00_010: ch = 8'h74;
         5'b00_011: ch = CH_SEMI;
         5'b01_001: ch = 8'h67;
         5'b01_010: ch = 8'h74;
         5'b01_011: ch = CH_SEMI;
         5'b10_001: ch = 8'h61;
         5'b10_010: ch = 8'h6D;
         5'b10_011: ch = 8'h70;
         5'b10_100: ch = CH_SEMI;
         5'b11_001: ch = 8'h71;
         5'b11_010: ch = 8'h75;
         5'b11_011: ch = 8'h6F;
         5'b11_100: ch = 8'h74;
         5'b11_101: ch = CH_SEMI;
         default:   ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [2:0] ent_len(input logic [1:0] e);
      logic [2:0] len;
      case (e)
         2'd0:    len = 3'd4;
         2'd1:    len = 3'd4;
         2'd2:    len = 3'd5;
         default: len = 3'd6;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] ent_char(input logic [1:0] e);
      logic [7:0] ch;
      case (e)
         2'd0:    ch = CH_LT;
         2'd1:    ch = CH_GT;
         2'd2:    ch = CH_AMP;
         default: ch = CH_QUOTE;
      endcase
      return ch;
   endfunction

endpackage

[design/trkvt_req_if.sv]
interface trkvt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] row_byte;
   logic       row_last;

   modport source (output valid, row_byte, row_last, input ready);
   modport sink (input valid, row_byte, row_last, output ready);
endinterface

[design/trkvt_rsp_if.sv]
interface trkvt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       part_kind;
   logic       part_end;
   logic       key_truncated;
   logic       row_done;
   logic       last;

   modport source (output valid, out_byte, byte_valid, part_kind, part_end,
                   key_truncated, row_done, last, input ready);
   modport sink (input valid, out_byte, byte_valid, part_kind, part_end,
                 key_truncated, row_done, last, output ready);
endinterface

[design/tag_row_key_value_tokenizer.sv]
// Path: a byte's command is registered in the queue, then in the back end, then as output beats.
// Throughput: a byte is accepted each cycle while the 2-entry command queue has room; the
// back end loads one command at a time, then sends its result beats (up to 8), one per cycle
// while the output is not stalled. Bytes that give no result never reach the back end.
// Reset (synchronous): scan state, counters, queue and output valid clear; held entity bytes do not.
module tag_row_key_value_tokenizer #(
   parameter int KEY_MAX = 32
) (
   input  logic        clock,
   input  logic        reset,
   trkvt_req_if.sink   req_bus,
   trkvt_rsp_if.source rsp_bus
);

   logic               q_push;
   logic               q_full;
   logic               q_pop;
   logic               q_empty;
   trkvt_pkg::cmd_type push_cmd;
   trkvt_pkg::cmd_type pop_cmd;

   trkvt_front #(
      .KEY_MAX (KEY_MAX)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_cmd   (push_cmd)
   );

   trkvt_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .pop_cmd  (pop_cmd)
   );

   trkvt_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_cmd   (pop_cmd),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

endmodule

[design/trkvt_front.sv]
module trkvt_front #(
   parameter int KEY_MAX = 32
) (
   input  logic                clock,
   input  logic                reset,
   trkvt_req_if.sink           req_bus,
   input  logic                q_full,
   output logic                q_push,
   output trkvt_pkg::cmd_type  q_cmd
);

   trkvt_pkg::mode_type mode_ff, mode_in;
   logic [7:0] hold_ff [trkvt_pkg::HOLD_DEPTH];
   logic [2:0] hold_cnt_ff, hold_cnt_in;
   logic [5:0] key_len_ff, key_len_in;
   logic       key_over_ff, key_over_in;

   logic       hold_wr_en;
   logic [2:0] hold_wr_idx;
   logic       accept;
   logic [7:0] c;
   logic [3:0] ent_hit;
   logic [3:0] ent_full;
   logic [7:0] ent_out;

   assign c           = req_bus.row_byte;
   assign req_bus.ready = !q_full;
   assign accept      = req_bus.valid && !q_full;

   // entity match of held bytes plus current byte
   always_comb begin
      logic same;
      ent_out = 8'h00;
      for (int e = 0; e < 4; e++) begin
         same = 1'b1;
         for (int i = 0; i < trkvt_pkg::HOLD_DEPTH; i++) begin
            if (3'(i) < hold_cnt_ff && hold_ff[i] != trkvt_pkg::ent_text(2'(e), 3'(i)))
               same = 1'b0;
         end
         ent_hit[e]  = ({1'b0, hold_cnt_ff} + 4'd1 <= {1'b0, trkvt_pkg::ent_len(2'(e))}) &&
                       same && (c == trkvt_pkg::ent_text(2'(e), hold_cnt_ff));
         ent_full[e] = ent_hit[e] &&
                       ({1'b0, hold_cnt_ff} + 4'd1 == {1'b0, trkvt_pkg::ent_len(2'(e))});
      end
      for (int e = 3; e >= 0; e--) begin
         if (ent_full[e])
            ent_out = trkvt_pkg::ent_char(2'(e));
      end
   end

   always_comb begin
      logic       run_key;
      logic       run_value;
      logic       plain;
      logic [5:0] klen;
      logic       kover;
      mode_in     = mode_ff;
      hold_cnt_in = hold_cnt_ff;
      key_len_in  = key_len_ff;
      key_over_in = key_over_ff;
      hold_wr_en  = 1'b0;
      hold_wr_idx = '0;
      q_cmd       = '0;
      run_key     = 1'b0;
      run_value   = 1'b0;
      plain       = 1'b0;
      klen        = key_len_ff;
      kover       = key_over_ff;

      for (int i = 0; i < trkvt_pkg::HOLD_DEPTH; i++)
         q_cmd.flush_bytes[i] = (3'(i) < hold_cnt_ff) ? hold_ff[i] : c;
      q_cmd.flush_bytes[trkvt_pkg::FLUSH_DEPTH-1] = c;

      case (mode_ff)
         trkvt_pkg::MODE_KEY: begin
            run_key = 1'b1;
         end
         trkvt_pkg::MODE_ATTR: begin
            if (c == trkvt_pkg::CH_GT)
               mode_in = trkvt_pkg::MODE_VALUE;
         end
         trkvt_pkg::MODE_VALUE: begin
            run_value = 1'b1;
         end
         trkvt_pkg::MODE_TAGOPEN: begin
            if (c == trkvt_pkg::CH_SLASH) begin
               mode_in = trkvt_pkg::MODE_CLOSE;
            end else begin
               klen    = '0;
               kover   = 1'b0;
               run_key = 1'b1;
            end
         end
         trkvt_pkg::MODE_CLOSE: begin
            if (c == trkvt_pkg::CH_GT)
               mode_in = trkvt_pkg::MODE_SEEK;
         end
         default: begin
            if (c == trkvt_pkg::CH_LT) begin
               mode_in     = trkvt_pkg::MODE_KEY;
               key_len_in  = '0;
               key_over_in = 1'b0;
            end else begin
               mode_in = trkvt_pkg::MODE_SEEK;
            end
         end
      endcase

      if (run_key) begin
         mode_in     = trkvt_pkg::MODE_KEY;
         key_len_in  = klen;
         key_over_in = kover;
         if (c == trkvt_pkg::CH_GT) begin
            q_cmd.key_end = 1'b1;
            mode_in       = trkvt_pkg::MODE_VALUE;
         end else if (c == trkvt_pkg::CH_SPACE) begin
            q_cmd.key_end = 1'b1;
            mode_in       = trkvt_pkg::MODE_ATTR;
         end else if (klen < 6'(KEY_MAX)) begin
            q_cmd.main_en   = 1'b1;
            q_cmd.main_byte = c;
            key_len_in      = klen + 6'd1;
         end else begin
            key_over_in = 1'b1;
         end
      end

      if (run_value) begin
         if (hold_cnt_ff == 3'd0 || hold_cnt_ff > 3'(trkvt_pkg::HOLD_DEPTH)) begin
            hold_cnt_in = '0;
            plain       = 1'b1;
         end else if (|ent_full) begin
            q_cmd.main_en   = 1'b1;
            q_cmd.main_byte = ent_out;
            q_cmd.main_kind = 1'b1;
            hold_cnt_in     = '0;
         end else if (|ent_hit && hold_cnt_ff < 3'(trkvt_pkg::HOLD_DEPTH)) begin
            hold_wr_en  = 1'b1;
            hold_wr_idx = hold_cnt_ff;
            hold_cnt_in = hold_cnt_ff + 3'd1;
         end else begin
            q_cmd.pre_cnt = hold_cnt_ff;
            hold_cnt_in   = '0;
            plain         = 1'b1;
         end
         if (plain) begin
            if (c == trkvt_pkg::CH_LT) begin
               q_cmd.value_end = 1'b1;
               mode_in         = trkvt_pkg::MODE_TAGOPEN;
            end else if (c == trkvt_pkg::CH_AMP) begin
               hold_wr_en  = 1'b1;
               hold_wr_idx = '0;
               hold_cnt_in = 3'd1;
            end else begin
               q_cmd.main_en   = 1'b1;
               q_cmd.main_byte = c;
               q_cmd.main_kind = 1'b1;
            end
         end
      end

      if (req_bus.row_last) begin
         case (mode_in)
            trkvt_pkg::MODE_KEY: begin
               q_cmd.key_end   = 1'b1;
               q_cmd.value_end = 1'b1;
            end
            trkvt_pkg::MODE_ATTR: begin
               q_cmd.value_end = 1'b1;
            end
            trkvt_pkg::MODE_VALUE: begin
               q_cmd.post_cnt  = hold_cnt_in;
               q_cmd.value_end = 1'b1;
            end
            default: begin
            end
         endcase
         q_cmd.row_done = 1'b1;
      end

      q_cmd.key_trunc = q_cmd.key_end && key_over_in;

      if (req_bus.row_last) begin
         mode_in     = trkvt_pkg::MODE_SEEK;
         hold_cnt_in = '0;
         key_len_in  = '0;
         key_over_in = 1'b0;
      end
   end

   assign q_push = accept &&
                   (q_cmd.pre_cnt != 3'd0 || q_cmd.main_en || q_cmd.key_end ||
                    q_cmd.post_cnt != 3'd0 || q_cmd.value_end || q_cmd.row_done);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= trkvt_pkg::MODE_SEEK;
         hold_cnt_ff <= '0;
         key_len_ff  <= '0;
         key_over_ff <= 1'b0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         hold_cnt_ff <= hold_cnt_in;
         key_len_ff  <= key_len_in;
         key_over_ff <= key_over_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && hold_wr_en)
         hold_ff[hold_wr_idx] <= c;
   end

endmodule

[design/trkvt_cmd_queue.sv]
module trkvt_cmd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  trkvt_pkg::cmd_type push_cmd,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output trkvt_pkg::cmd_type pop_cmd
);

   localparam int PTR_W = $clog2(trkvt_pkg::QUEUE_DEPTH);

   trkvt_pkg::cmd_type entry_ff [trkvt_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;

   assign full    = count_ff == (PTR_W+1)'(trkvt_pkg::QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign pop_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push && !full) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
         count_in  = count_in + 1'b1;
      end
      if (pop && !empty) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
         count_in  = count_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full)
         entry_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

[design/trkvt_back.sv]
module trkvt_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  trkvt_pkg::cmd_type q_cmd,
   output logic               q_pop,
   trkvt_rsp_if.source        rsp_bus
);

   logic       busy_ff, busy_in;
   logic [trkvt_pkg::FLUSH_DEPTH-1:0][7:0] flush_ff, flush_in;
   logic [2:0] idx_ff, idx_in;
   logic [2:0] pre_ff, pre_in;
   logic [2:0] post_ff, post_in;
   logic       main_en_ff, main_en_in;
   logic [7:0] main_byte_ff, main_byte_in;
   logic       main_kind_ff, main_kind_in;
   logic       kend_ff, kend_in;
   logic       ktrunc_ff, ktrunc_in;
   logic       vend_ff, vend_in;
   logic       done_ff, done_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       byte_valid_ff, byte_valid_in;
   logic       part_kind_ff, part_kind_in;
   logic       part_end_ff, part_end_in;
   logic       trunc_ff, trunc_in;
   logic       row_done_ff, row_done_in;
   logic       last_ff, last_in;

   logic       can_out;
   logic       emit;

   assign can_out = !rsp_valid_ff || rsp_bus.ready;
   assign emit    = busy_ff && can_out;
   assign q_pop   = !busy_ff && !q_empty;

   always_comb begin
      busy_in       = busy_ff;
      flush_in      = flush_ff;
      idx_in        = idx_ff;
      pre_in        = pre_ff;
      post_in       = post_ff;
      main_en_in    = main_en_ff;
      main_byte_in  = main_byte_ff;
      main_kind_in  = main_kind_ff;
      kend_in       = kend_ff;
      ktrunc_in     = ktrunc_ff;
      vend_in       = vend_ff;
      done_in       = done_ff;
      out_byte_in   = out_byte_ff;
      byte_valid_in = byte_valid_ff;
      part_kind_in  = part_kind_ff;
      part_end_in   = part_end_ff;
      trunc_in      = trunc_ff;
      row_done_in   = row_done_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;

      if (q_pop) begin
         busy_in      = 1'b1;
         flush_in     = q_cmd.flush_bytes;
         idx_in       = '0;
         pre_in       = q_cmd.pre_cnt;
         post_in      = q_cmd.post_cnt;
         main_en_in   = q_cmd.main_en;
         main_byte_in = q_cmd.main_byte;
         main_kind_in = q_cmd.main_kind;
         kend_in      = q_cmd.key_end;
         ktrunc_in    = q_cmd.key_trunc;
         vend_in      = q_cmd.value_end;
         done_in      = q_cmd.row_done;
      end else if (emit) begin
         rsp_valid_in  = 1'b1;
         out_byte_in   = '0;
         byte_valid_in = 1'b0;
         part_kind_in  = 1'b0;
         part_end_in   = 1'b0;
         trunc_in      = 1'b0;
         row_done_in   = 1'b0;
         if (pre_ff != 3'd0) begin
            out_byte_in   = flush_ff[idx_ff];
            byte_valid_in = 1'b1;
            part_kind_in  = 1'b1;
            pre_in        = pre_ff - 3'd1;
            idx_in        = idx_ff + 3'd1;
         end else if (main_en_ff) begin
            out_byte_in   = main_byte_ff;
            byte_valid_in = 1'b1;
            part_kind_in  = main_kind_ff;
            main_en_in    = 1'b0;
         end else if (kend_ff) begin
            part_end_in = 1'b1;
            trunc_in    = ktrunc_ff;
            kend_in     = 1'b0;
         end else if (post_ff != 3'd0) begin
            out_byte_in   = flush_ff[idx_ff];
            byte_valid_in = 1'b1;
            part_kind_in  = 1'b1;
            post_in       = post_ff - 3'd1;
            idx_in        = idx_ff + 3'd1;
         end else if (vend_ff) begin
            part_end_in  = 1'b1;
            part_kind_in = 1'b1;
            vend_in      = 1'b0;
         end else begin
            row_done_in = 1'b1;
            done_in     = 1'b0;
         end
         last_in = pre_in == 3'd0 && !main_en_in && !kend_in && post_in == 3'd0 &&
                   !vend_in && !done_in;
         busy_in = !last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      flush_ff      <= flush_in;
      idx_ff        <= idx_in;
      pre_ff        <= pre_in;
      post_ff       <= post_in;
      main_en_ff    <= main_en_in;
      main_byte_ff  <= main_byte_in;
      main_kind_ff  <= main_kind_in;
      kend_ff       <= kend_in;
      ktrunc_ff     <= ktrunc_in;
      vend_ff       <= vend_in;
      done_ff       <= done_in;
      out_byte_ff   <= out_byte_in;
      byte_valid_ff <= byte_valid_in;
      part_kind_ff  <= part_kind_in;
      part_end_ff   <= part_end_in;
      trunc_ff      <= trunc_in;
      row_done_ff   <= row_done_in;
      last_ff       <= last_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.out_byte      = out_byte_ff;
   assign rsp_bus.byte_valid    = byte_valid_ff;
   assign rsp_bus.part_kind     = part_kind_ff;
   assign rsp_bus.part_end      = part_end_ff;
   assign rsp_bus.key_truncated = trunc_ff;
   assign rsp_bus.row_done      = row_done_ff;
   assign rsp_bus.last          = last_ff;

endmodule

[bench/token_stream_checker.sv]
`timescale 1ns / 1ps

module token_stream_checker #(
   parameter int KEY_MAX = 32
) (
   input  logic        clock,
   input  logic        reset,
   trkvt_req_if        req_bus,
   trkvt_rsp_if        rsp_bus,
   output int unsigned pending,
   output int unsigned mismatches
);

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       part_kind;
      logic       part_end;
      logic       key_truncated;
      logic       row_done;
      logic       last;
   } token_type;

   string      ent_word [4] = '{"&lt;", "&gt;", "&amp;", "&quot;"};
   logic [7:0] ent_char [4] = '{trkvt_pkg::CH_LT, trkvt_pkg::CH_GT, trkvt_pkg::CH_AMP,
                                trkvt_pkg::CH_QUOTE};

   trkvt_pkg::mode_type scan;
   logic [7:0] held [trkvt_pkg::HOLD_DEPTH];
   int         held_n;
   int         key_len;
   bit         key_over;

   token_type   token_q [$];
   token_type   step_q [$];
   int unsigned bad_beats = 0;

   function void emit_token(logic [7:0] b, bit bv, bit kind, bit fin, bit trunc, bit done);
      token_type t;
      if (step_q.size() >= 8) return;
      t = '{b, bv, kind, fin, trunc, done, 1'b0};
      step_q.push_back(t);
   endfunction

   function void clear_scan();
      scan     = trkvt_pkg::MODE_SEEK;
      held_n   = 0;
      key_len  = 0;
      key_over = 1'b0;
   endfunction

   function void close_key();
      emit_token(8'h00, 0, 0, 1, key_over, 0);
   endfunction

   function void close_value();
      emit_token(8'h00, 0, 1, 1, 0, 0);
   endfunction

   function void begin_key();
      key_len  = 0;
      key_over = 1'b0;
      scan     = trkvt_pkg::MODE_KEY;
   endfunction

   function void take_key_char(logic [7:0] c);
      if (c == trkvt_pkg::CH_GT) begin
         close_key();
         scan = trkvt_pkg::MODE_VALUE;
      end else if (c == trkvt_pkg::CH_SPACE) begin
         close_key();
         scan = trkvt_pkg::MODE_ATTR;
      end else if (key_len < KEY_MAX) begin
         emit_token(c, 1, 0, 0, 0, 0);
         key_len = (key_len + 1) & 63;
      end else begin
         key_over = 1'b1;
      end
   endfunction

   function void release_held();
      for (int i = 0; i < held_n && i < trkvt_pkg::HOLD_DEPTH; i++)
         emit_token(held[i], 1, 1, 0, 0, 0);
      held_n = 0;
   endfunction

   function void take_plain_value(logic [7:0] c);
      if (c == trkvt_pkg::CH_LT) begin
         close_value();
         scan = trkvt_pkg::MODE_TAGOPEN;
      end else if (c == trkvt_pkg::CH_AMP) begin
         held[0] = c;
         held_n  = 1;
      end else begin
         emit_token(c, 1, 1, 0, 0, 0);
      end
   endfunction

   function void take_value_char(logic [7:0] c);
      int n;
      bit prefix;
      bit same;
      n      = held_n;
      prefix = 1'b0;
      if (n == 0 || n > trkvt_pkg::HOLD_DEPTH) begin
         held_n = 0;
         take_plain_value(c);
         return;
      end
      for (int e = 0; e < 4; e++) begin
         if (n + 1 > ent_word[e].len()) continue;
         same = 1'b1;
         for (int i = 0; i < n; i++)
            if (held[i] != ent_word[e][i]) same = 1'b0;
         if (!same || c != ent_word[e][n]) continue;
         if (n + 1 == ent_word[e].len()) begin
            emit_token(ent_char[e], 1, 1, 0, 0, 0);
            held_n = 0;
            return;
         end
         prefix = 1'b1;
      end
      if (prefix && n < trkvt_pkg::HOLD_DEPTH) begin
         held[n] = c;
         held_n  = n + 1;
         return;
      end
      release_held();
      take_plain_value(c);
   endfunction

   function void tokenize_byte(logic [7:0] c, bit row_end);
      step_q.delete();
      case (scan)
         trkvt_pkg::MODE_KEY: take_key_char(c);
         trkvt_pkg::MODE_ATTR: if (c == trkvt_pkg::CH_GT) scan = trkvt_pkg::MODE_VALUE;
         trkvt_pkg::MODE_VALUE: take_value_char(c);
         trkvt_pkg::MODE_TAGOPEN: begin
            if (c == trkvt_pkg::CH_SLASH) begin
               scan = trkvt_pkg::MODE_CLOSE;
            end else begin
               begin_key();
               take_key_char(c);
            end
         end
         trkvt_pkg::MODE_CLOSE: if (c == trkvt_pkg::CH_GT) scan = trkvt_pkg::MODE_SEEK;
         default: begin
            if (c == trkvt_pkg::CH_LT) begin_key();
            else scan = trkvt_pkg::MODE_SEEK;
         end
      endcase
      if (row_end) begin
         if (scan == trkvt_pkg::MODE_KEY) begin
            close_key();
            close_value();
         end else if (scan == trkvt_pkg::MODE_ATTR) begin
            close_value();
         end else if (scan == trkvt_pkg::MODE_VALUE) begin
            release_held();
            close_value();
         end
         emit_token(8'h00, 0, 0, 0, 0, 1);
         clear_scan();
      end
      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
      foreach (step_q[i]) token_q.push_back(step_q[i]);
   endfunction

   function bit field_ok(string name, int want, int got);
      if (want == got) return 1'b1;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      token_type want;
      bit        ok;
      if (reset) begin
         clear_scan();
         token_q.delete();
      end else begin
         if (req_bus.valid && req_bus.ready)
            tokenize_byte(req_bus.row_byte, req_bus.row_last);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (token_q.size() == 0) begin
               $display("%0t: unexpected beat, expected none, got byte %0h end %0b done %0b",
                        $time, rsp_bus.out_byte, rsp_bus.part_end, rsp_bus.row_done);
               bad_beats++;
            end else begin
               want = token_q.pop_front();
               ok = field_ok("out_byte", want.out_byte, rsp_bus.out_byte)
                  & field_ok("byte_valid", want.byte_valid, rsp_bus.byte_valid)
                  & field_ok("part_kind", want.part_kind, rsp_bus.part_kind)
                  & field_ok("part_end", want.part_end, rsp_bus.part_end)
                  & field_ok("key_truncated", want.key_truncated, rsp_bus.key_truncated)
                  & field_ok("row_done", want.row_done, rsp_bus.row_done)
                  & field_ok("last", want.last, rsp_bus.last);
               if (!ok) bad_beats++;
            end
         end
      end
      pending    <= token_q.size();
      mismatches <= bad_beats;
   end

endmodule

[bench/tag_row_key_value_tokenizer_tb.sv]
`timescale 1ns / 1ps

module tag_row_key_value_tokenizer_tb;

   localparam int KEY_MAX = 32;
   localparam int ITEMS   = 300;

   logic        clock = 1'b0;
   logic        reset;
   int unsigned pending;
   int unsigned mismatches;

   bit gappy;
   bit calm;
   bit squeeze;

   logic [7:0] row_q [$];
   string      ent_word [4] = '{"&lt;", "&gt;", "&amp;", "&quot;"};

   trkvt_req_if req_bus ();
   trkvt_rsp_if rsp_bus ();

   tag_row_key_value_tokenizer #(.KEY_MAX(KEY_MAX)) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   token_stream_checker #(.KEY_MAX(KEY_MAX)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .pending    (pending),
      .mismatches (mismatches)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin : watchdog
      #500000;
      $display("[FAIL] regression broken");
      $finish;
   end

   task put_byte(input logic [7:0] b, input bit row_end);
      if (!calm && gappy && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.row_byte <= b;
      req_bus.row_last <= row_end;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task put_text(input string s, input bit row_end);
      for (int i = 0; i < s.len(); i++)
         put_byte(s[i], row_end && i == s.len() - 1);
   endtask

   function void add_text(string s);
      for (int i = 0; i < s.len(); i++) row_q.push_back(s[i]);
   endfunction

   function logic [7:0] letter();
      return 8'h61 + 8'($urandom_range(0, 25));
   endfunction

   // elements with random content, some without a closing tag or '>', plus noise and cut rows
   function void make_row();
      logic [7:0] key [$];
      int         klen;
      int         n;
      string      w;
      row_q.delete();
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 12)) row_q.push_back(8'($urandom_range(0, 255)));
         return;
      end
      repeat ($urandom_range(1, 3)) begin
         key.delete();
         klen = ($urandom_range(0, 14) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 6);
         repeat (klen)
            key.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : letter());
         row_q.push_back(trkvt_pkg::CH_LT);
         foreach (key[i]) row_q.push_back(key[i]);
         if ($urandom_range(0, 3) == 0) begin
            row_q.push_back(trkvt_pkg::CH_SPACE);
            repeat ($urandom_range(0, 4)) row_q.push_back(letter());
            add_text("=\"v\"");
         end
         row_q.push_back(($urandom_range(0, 11) == 0) ? letter() : trkvt_pkg::CH_GT);
         repeat ($urandom_range(0, 8)) begin
            w = ent_word[$urandom_range(0, 3)];
            case ($urandom_range(0, 9))
               0, 1:    add_text(w);
               2:       add_text(w.substr(0, $urandom_range(0, w.len() - 2)));
               3:       row_q.push_back(trkvt_pkg::CH_AMP);
               4:       row_q.push_back(8'($urandom_range(0, 255)));
               default: row_q.push_back(letter());
            endcase
         end
         if ($urandom_range(0, 2) != 0) begin
            add_text("</");
            foreach (key[i]) row_q.push_back(key[i]);
            row_q.push_back(trkvt_pkg::CH_GT);
         end
      end
      if ($urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, row_q.size());
         while (row_q.size() > n) void'(row_q.pop_back());
      end
   endfunction

   initial begin : drain
      rsp_bus.ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (squeeze) begin
            squeeze = 1'b0;
            rsp_bus.ready <= 1'b0;
            for (int k = 0; k < 300; k++) @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int sent;
      reset            = 1'b1;
      gappy            = 1'b1;
      calm             = 1'b0;
      squeeze          = 1'b0;
      req_bus.valid    = 1'b0;
      req_bus.row_byte = 8'h00;
      req_bus.row_last = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // attributes, then row end with a full hold buffer
      put_text("<a b>&quot", 1'b1);
      // extreme bytes, entity, unmatched ampersand, new tag without slash, open key at end
      put_text("<", 1'b0);
      put_byte(8'h00, 1'b0);
      put_text(">", 1'b0);
      put_byte(8'hFF, 1'b0);
      put_text("&gt;&x<c", 1'b1);
      // row ends inside a closing tag
      put_text("<d>x</", 1'b1);

      sent = 0;
      while (sent < ITEMS) begin
         make_row();
         gappy = ($urandom_range(0, 2) != 0);
         calm  = (sent >= ITEMS * 4 / 5);
         if (sent > 0 && sent < 40) squeeze = 1'b1;
         foreach (row_q[i]) begin
            put_byte(row_q[i], i == row_q.size() - 1);
            sent++;
         end
      end
      req_bus.valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (pending != 0)
         $display("%0t: %0d expected beats never arrived", $time, pending);
      if (mismatches == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
